// ===== hdl/rpcb_pkg.sv =====
// shared types, constants and helper functions for the rectangle coverage bitmap
// used by every module of the block except rpcb_ram; depends on nothing
package rpcb_pkg;

    localparam int GRID_SIZE = 512;
    localparam int COORD_W   = 10;
    localparam int ROW_W     = $clog2(GRID_SIZE);
    localparam int QDEPTH    = 2;

    localparam logic ACT_PAINT = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [COORD_W-1:0]   coord_t;
    typedef logic [GRID_SIZE-1:0] row_t;

    typedef struct packed {
        logic   query;
        logic   empty;
        coord_t xl;
        coord_t xh;
        coord_t yl;
        coord_t yh;
    } item_t;

    function automatic coord_t clamp_coord(coord_t v);
        coord_t r;
        r = ({1'b0, v} > (COORD_W+1)'(GRID_SIZE)) ? COORD_W'(GRID_SIZE) : v;
        return r;
    endfunction

    // bits lo..hi-1 set
    function automatic row_t span_mask(coord_t lo, coord_t hi);
        row_t m;
        for (int i = 0; i < GRID_SIZE; i++) begin
            m[i] = ((COORD_W+1)'(i) >= {1'b0, lo}) && ((COORD_W+1)'(i) < {1'b0, hi});
        end
        return m;
    endfunction

endpackage

// ===== hdl/rectangle_paint_coverage_bitmap_core.sv =====
// Rectangle coverage bitmap: a GRID_SIZE x GRID_SIZE bitmap, cleared after reset, that
// paints half-open rectangles as covered or answers whether one is fully covered.
// Bitmap rows are stored one full row per RAM word, so the engine handles one row per
// cycle, walking the rows of an item (after clamping) in turn; an empty query goes
// straight to its result and an empty paint is dropped at the input. Paint is a
// read-modify-write over the single RAM read and write ports. After reset, a clearing
// pass over all GRID_SIZE rows zeroes the bitmap and s_ready stays low meanwhile. A
// two-beat queue lets the input keep accepting while a row walk runs, and an output
// register holds a query result until m_ready takes it.
// depends on rpcb_pkg, rpcb_front, rpcb_queue, rpcb_back
module rectangle_paint_coverage_bitmap_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  rpcb_pkg::coord_t    s_x_low,
    input  rpcb_pkg::coord_t    s_y_low,
    input  rpcb_pkg::coord_t    s_x_high,
    input  rpcb_pkg::coord_t    s_y_high,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_fully_covered
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    rpcb_pkg::item_t   push_item;
    rpcb_pkg::item_t   head;
    logic              clearing;

    rpcb_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_x_low  (s_x_low),
        .s_y_low  (s_y_low),
        .s_x_high (s_x_high),
        .s_y_high (s_y_high),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rpcb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    rpcb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .q_not_empty     (q_not_empty),
        .pop             (q_pop),
        .clearing        (clearing),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fully_covered (m_fully_covered)
    );

endmodule

// ===== hdl/rpcb_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
module rpcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rpcb_front.sv =====
// front end: accepts input beats, clamps coordinates and classifies the rectangle
// depends on rpcb_pkg; feeds rpcb_queue
module rpcb_front (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  rpcb_pkg::coord_t        s_x_low,
    input  rpcb_pkg::coord_t        s_y_low,
    input  rpcb_pkg::coord_t        s_x_high,
    input  rpcb_pkg::coord_t        s_y_high,
    input  logic                    clearing,
    input  logic                    q_full,
    output logic                    q_push,
    output rpcb_pkg::item_t         q_item
);

    rpcb_pkg::coord_t xl, xh, yl, yh;
    logic             empty;

    always_comb begin
        xl    = rpcb_pkg::clamp_coord(s_x_low);
        xh    = rpcb_pkg::clamp_coord(s_x_high);
        yl    = rpcb_pkg::clamp_coord(s_y_low);
        yh    = rpcb_pkg::clamp_coord(s_y_high);
        empty = (xl >= xh) || (yl >= yh);
    end

    assign s_ready = !clearing && !q_full;

    // an empty paint has no effect and is dropped here
    assign q_push = s_valid && s_ready && !(s_action == rpcb_pkg::ACT_PAINT && empty);

    always_comb begin
        q_item.query = (s_action == rpcb_pkg::ACT_QUERY);
        q_item.empty = empty;
        q_item.xl    = xl;
        q_item.xh    = xh;
        q_item.yl    = yl;
        q_item.yh    = yh;
    end

endmodule

// ===== hdl/rpcb_queue.sv =====
// short fifo of classified items between the front end and the row engine
// depends on rpcb_pkg
module rpcb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rpcb_pkg::item_t   push_item,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output rpcb_pkg::item_t   head
);

    localparam int PTR_W = $clog2(rpcb_pkg::QDEPTH);
    localparam int CNT_W = $clog2(rpcb_pkg::QDEPTH + 1);

    rpcb_pkg::item_t  entry_reg [rpcb_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(rpcb_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rpcb_pkg::QDEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rpcb_pkg::QDEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(rpcb_pkg::QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== hdl/rpcb_back.sv =====
// row engine: clears the bitmap after reset, then walks the rows of each rectangle,
// painting by read-modify-write or checking coverage; holds the result register
// depends on rpcb_pkg and rpcb_ram
module rpcb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpcb_pkg::item_t   head,
    input  logic              q_not_empty,
    output logic              pop,
    output logic              clearing,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_fully_covered
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_RUN    = 5'b00100,
        ST_TAIL   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [rpcb_pkg::ROW_W-1:0]     clr_cnt_reg, clr_cnt_next;
    rpcb_pkg::coord_t               x_reg, x_next;
    rpcb_pkg::coord_t               xh_reg, xh_next;
    logic                           query_reg, query_next;
    rpcb_pkg::row_t                 mask_reg, mask_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic [rpcb_pkg::ROW_W-1:0]     rd_row_reg, rd_row_next;
    logic                           covered_reg, covered_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_covered_reg, m_covered_next;

    logic                           ram_we;
    logic [rpcb_pkg::ROW_W-1:0]     ram_waddr;
    rpcb_pkg::row_t                 ram_wdata;
    logic                           ram_re;
    rpcb_pkg::row_t                 ram_rdata;

    rpcb_ram #(
        .WIDTH (rpcb_pkg::GRID_SIZE),
        .DEPTH (rpcb_pkg::GRID_SIZE)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (x_reg[rpcb_pkg::ROW_W-1:0]),
        .rdata (ram_rdata)
    );

    assign clearing        = (state_reg == ST_CLEAR);
    assign pop             = (state_reg == ST_IDLE) && q_not_empty;
    assign ram_re          = (state_reg == ST_RUN);
    assign m_valid         = m_valid_reg;
    assign m_fully_covered = m_covered_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rd_row_reg;
        ram_wdata = ram_rdata | mask_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (rd_valid_reg && !query_reg) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        x_next         = x_reg;
        xh_next        = xh_reg;
        query_next     = query_reg;
        mask_next      = mask_reg;
        rd_valid_next  = (state_reg == ST_RUN);
        rd_row_next    = x_reg[rpcb_pkg::ROW_W-1:0];
        covered_next   = covered_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_covered_next = m_covered_reg;

        if (rd_valid_reg && query_reg && ((ram_rdata & mask_reg) != mask_reg)) begin
            covered_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + rpcb_pkg::ROW_W'(1);
                if (clr_cnt_reg == rpcb_pkg::ROW_W'(rpcb_pkg::GRID_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_not_empty) begin
                    query_next   = head.query;
                    x_next       = head.xl;
                    xh_next      = head.xh;
                    mask_next    = rpcb_pkg::span_mask(head.yl, head.yh);
                    covered_next = 1'b1;
                    state_next   = head.empty ? ST_RESULT : ST_RUN;
                end
            end
            ST_RUN: begin
                x_next = x_reg + rpcb_pkg::COORD_W'(1);
                if (x_next == xh_reg) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = query_reg ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_covered_next = covered_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        xh_reg        <= xh_next;
        query_reg     <= query_next;
        mask_reg      <= mask_next;
        rd_row_reg    <= rd_row_next;
        covered_reg   <= covered_next;
        m_covered_reg <= m_covered_next;
    end

`ifndef ASSERT_OFF
    a_query_never_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != ST_CLEAR) |-> !query_reg)
        else $error("bitmap written while a query is in progress");

    a_result_from_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result beat raised outside the result state");

    a_row_in_rectangle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (x_reg < xh_reg))
        else $error("row walk past the rectangle");

    a_pop_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == ST_RUN || state_reg == ST_RESULT))
        else $error("popped item not started");
`endif

endmodule
